// ===== sv/kfe_pkg.sv =====
// Shared types and constants for the keyframe LED fade engine.
package kfe_pkg;

    // Field widths fixed by the interface
    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 14;
    localparam int LEVEL_W  = 8;
    localparam int SLOPE_W  = 8;
    localparam int DUTY_W   = 8;
    localparam int FRAME_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int ACC_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    // Defaults and reset values
    localparam int MAX_FRAMES_DEF = 16;
    localparam logic [COUNT_W-1:0]      FRAME_COUNT_RST = COUNT_W'(1);
    localparam logic [TIME_W-1:0]       WRAP_TIME_RST   = TIME_W'(12000);
    localparam logic signed [ACC_W-1:0] ACC_RST         = ACC_W'(16);
    localparam logic [DUTY_W-1:0]       DUTY_MAX        = DUTY_W'(255);

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_TIME   = CFG_IDX_W'(1);

    // One input word
    typedef struct packed {
        logic                      op;
        logic [SLOT_W-1:0]         slot;
        logic [TIME_W-1:0]         ftime;
        logic [LEVEL_W-1:0]        level;
        logic signed [SLOPE_W-1:0] slope;
    } t_item;

    // One result word
    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [FRAME_W-1:0] frame;
    } t_result;

endpackage

// ===== sv/kfe_in_reg.sv =====
// Input register stage: holds one accepted word until the core takes it.
module kfe_in_reg
    import kfe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_out_busy,
    output logic  o_go,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  advance;

    // Ticks wait while the result register is full and stalled; writes never wait
    assign advance = !((r_item.op == OP_TICK) && i_out_busy);
    assign o_go    = r_valid && advance;
    assign o_stall = r_valid && !advance;
    assign o_item  = r_item;

    // Hold control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/kfe_core.sv =====
// Keyframe tables, time counter, level accumulator and duty computation.
module kfe_core
    import kfe_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_go,
    input  t_item                 i_item,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [TIME_W-1:0]         r_time_tab  [MAX_FRAMES];
    logic [LEVEL_W-1:0]        r_level_tab [MAX_FRAMES];
    logic signed [SLOPE_W-1:0] r_slope_tab [MAX_FRAMES];
    logic signed [SLOPE_W-1:0] r_cur_slope;

    logic [FW-1:0]             r_cur;
    logic signed [ACC_W-1:0]   r_acc;
    logic [TIME_W-1:0]         r_time;
    logic [COUNT_W-1:0]        r_frame_count;
    logic [TIME_W-1:0]         r_wrap_time;

    logic                      is_tick;
    logic                      is_write;
    logic                      slot_ok;
    logic [FW-1:0]             wr_idx;
    logic [FW:0]               nxt_w;
    logic [FW-1:0]             nxt;
    logic                      hit;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [SLOPE_W-1:0] slope_use;
    logic signed [ACC_W:0]     sum;
    logic signed [ACC_W-1:0]   n_acc;
    logic [FW-1:0]             n_cur;
    logic [TIME_W-1:0]         n_time;
    logic [DUTY_W-1:0]         duty;

    assign is_tick  = i_go && (i_item.op == OP_TICK);
    assign is_write = i_go && (i_item.op == OP_WRITE);
    assign slot_ok  = 32'(i_item.slot) < MAX_FRAMES;
    assign wr_idx   = FW'(i_item.slot);

    // Pick the keyframe after the current one, wrap to slot 0
    always_comb begin
        nxt_w = (FW+1)'(r_cur) + (FW+1)'(1);
        if ((32'(nxt_w) >= 32'(r_frame_count)) || (32'(nxt_w) >= MAX_FRAMES)) begin
            nxt = '0;
        end else begin
            nxt = FW'(nxt_w);
        end
    end

    // Load the keyframe level on a time match, then add the slope with saturation
    always_comb begin
        hit = (r_time_tab[nxt] == r_time);
        if (hit) begin
            acc_base  = {{(ACC_W-LEVEL_W-4){1'b0}}, r_level_tab[nxt], 4'b0000};
            slope_use = r_slope_tab[nxt];
            n_cur     = nxt;
        end else begin
            acc_base  = r_acc;
            slope_use = r_cur_slope;
            n_cur     = r_cur;
        end
        sum = {acc_base[ACC_W-1], acc_base}
            + {{(ACC_W+1-SLOPE_W){slope_use[SLOPE_W-1]}}, slope_use};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            n_acc = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            n_acc = sum[ACC_W-1:0];
        end
    end

    // Clamp the integer part to a duty value
    always_comb begin
        if (n_acc[ACC_W-1]) begin
            duty = '0;
        end else if (|n_acc[ACC_W-2:12]) begin
            duty = DUTY_MAX;
        end else begin
            duty = n_acc[11:4];
        end
    end

    // Advance time, wrap past the last value
    assign n_time = (r_time >= r_wrap_time) ? '0 : r_time + TIME_W'(1);

    assign o_res_valid = is_tick;
    assign o_res.duty  = duty;
    assign o_res.frame = FRAME_W'(n_cur);

    // Keyframe tables and the slope of the current keyframe
    always_ff @(posedge i_clk) begin
        if (is_write && slot_ok) begin
            r_time_tab[wr_idx]  <= i_item.ftime;
            r_level_tab[wr_idx] <= i_item.level;
            r_slope_tab[wr_idx] <= i_item.slope;
            if (wr_idx == r_cur) begin
                r_cur_slope <= i_item.slope;
            end
        end else if (is_tick && hit) begin
            r_cur_slope <= r_slope_tab[nxt];
        end
    end

    // Engine state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur         <= '0;
            r_acc         <= ACC_RST;
            r_time        <= '0;
            r_frame_count <= FRAME_COUNT_RST;
            r_wrap_time   <= WRAP_TIME_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_WRAP_TIME:   r_wrap_time   <= i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (is_tick) begin
                r_cur  <= n_cur;
                r_acc  <= n_acc;
                r_time <= n_time;
            end
        end
    end

endmodule

// ===== sv/kfe_out_reg.sv =====
// Result register: holds one result word until the receiver takes it.
module kfe_out_reg
    import kfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Set on a new result, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Capture result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/keyframe_led_fade_engine_top.sv =====
// Top level of one keyframe LED fade engine channel.
// One word is accepted every cycle while the input is not stalled: a write word stores a
// keyframe, a tick word advances the channel by one time step and yields one result word
// (duty and active keyframe) on the outputs through an input register and a result
// register. The keyframe match, slope add and clamp run combinationally against the
// engine state, so consecutive ticks need no gap. The input stalls only while a tick
// waits behind a stalled result word. Configuration writes are taken at once (ready is
// always high) and must only be issued while no word is in flight.
module keyframe_led_fade_engine_top
    import kfe_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_operation,
    input  logic [SLOT_W-1:0]         i_frame_slot,
    input  logic [TIME_W-1:0]         i_frame_time,
    input  logic [LEVEL_W-1:0]        i_frame_level,
    input  logic signed [SLOPE_W-1:0] i_frame_slope,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [DUTY_W-1:0]         o_duty,
    output logic [FRAME_W-1:0]        o_active_frame,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_item   in_item;
    t_item   s1_item;
    logic    s1_go;
    logic    out_busy;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.op    = i_operation;
    assign in_item.slot  = i_frame_slot;
    assign in_item.ftime = i_frame_time;
    assign in_item.level = i_frame_level;
    assign in_item.slope = i_frame_slope;

    assign o_cfg_ready = 1'b1;

    kfe_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_item     (in_item),
        .o_stall    (o_in_stall),
        .i_out_busy (out_busy),
        .o_go       (s1_go),
        .o_item     (s1_item)
    );

    kfe_core #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_go        (s1_go),
        .i_item      (s1_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    kfe_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_out_stall),
        .o_busy  (out_busy),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_duty         = out_res.duty;
    assign o_active_frame = out_res.frame;

endmodule

// ===== sv/kfe_checker.sv =====
// Port-level checks for the fade engine, bound to the top level.
module kfe_checker
    import kfe_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [DUTY_W-1:0]         o_duty,
    input logic [FRAME_W-1:0]        o_active_frame
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_duty) && $stable(o_active_frame))
        else $error("result payload changed while stalled");

    // Input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind keyframe_led_fade_engine_top kfe_checker u_kfe_checker (.*);
